>>> rtl/core/acet_pkg.sv
`default_nettype none
package acet_pkg;

  localparam int ID_W    = 6;
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 16;
  localparam int SCALE_W = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd100;

  localparam int MAX_COLLIDERS_DEFAULT = 64;
  localparam int QUEUE_DEPTH           = 2;

  typedef struct packed {
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic            pair_ok;
    logic            hit;
  } pair_item_t;

endpackage
`default_nettype wire

>>> rtl/core/acet_front.sv
`default_nettype none
module acet_front #(
  parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [acet_pkg::SCALE_W-1:0]        cfg_wdata,
  input  wire logic                                hold,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [acet_pkg::ID_W-1:0]           first_id,
  input  wire logic [acet_pkg::ID_W-1:0]           second_id,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_center_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_center_y,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_center_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_center_y,
  input  wire logic [acet_pkg::SIZE_W-1:0]         first_width,
  input  wire logic [acet_pkg::SIZE_W-1:0]         first_height,
  input  wire logic [acet_pkg::SIZE_W-1:0]         second_width,
  input  wire logic [acet_pkg::SIZE_W-1:0]         second_height,
  output logic                                     push,
  output acet_pkg::pair_item_t                     push_item,
  input  wire logic                                full
);

  localparam int DIFF_W  = acet_pkg::COORD_W + 1;
  localparam int SUM_W   = acet_pkg::SIZE_W + 1;
  localparam int REACH_W = SUM_W + acet_pkg::SCALE_W;
  localparam int MAG_W   = DIFF_W;
  localparam int MAG2_W  = MAG_W + 1;
  localparam int CMP_W   = (REACH_W > MAG2_W) ? REACH_W : MAG2_W;

  logic [acet_pkg::SCALE_W-1:0] size_scale;

  // stage 1: center differences, size sums, id check
  logic                       f1_valid;
  logic signed [DIFF_W-1:0]   f1_dx;
  logic signed [DIFF_W-1:0]   f1_dy;
  logic [SUM_W-1:0]           f1_sx;
  logic [SUM_W-1:0]           f1_sy;
  logic [acet_pkg::ID_W-1:0]  f1_a;
  logic [acet_pkg::ID_W-1:0]  f1_b;
  logic                       f1_ok;

  // stage 2: doubled magnitudes, scaled reach
  logic                       f2_valid;
  logic [MAG2_W-1:0]          f2_mx;
  logic [MAG2_W-1:0]          f2_my;
  logic [REACH_W-1:0]         f2_rx;
  logic [REACH_W-1:0]         f2_ry;
  logic [acet_pkg::ID_W-1:0]  f2_a;
  logic [acet_pkg::ID_W-1:0]  f2_b;
  logic                       f2_ok;

  logic              in_take;
  logic              f2_free;
  logic              f1_adv;
  logic              pair_ok;
  logic [MAG_W-1:0]  abs_x;
  logic [MAG_W-1:0]  abs_y;

  assign f2_free  = !f2_valid || !full;
  assign f1_adv   = f1_valid && f2_free;
  assign in_stall = hold || (f1_valid && !f2_free);
  assign in_take  = in_valid && !in_stall;
  assign push     = f2_valid && !full;

  assign pair_ok = (first_id != second_id) &&
                   (32'(first_id) < 32'(MAX_COLLIDERS)) &&
                   (32'(second_id) < 32'(MAX_COLLIDERS));

  assign abs_x = f1_dx[DIFF_W-1] ? MAG_W'(-f1_dx) : MAG_W'(f1_dx);
  assign abs_y = f1_dy[DIFF_W-1] ? MAG_W'(-f1_dy) : MAG_W'(f1_dy);

  always_comb begin
    push_item.first_id  = f2_a;
    push_item.second_id = f2_b;
    push_item.pair_ok   = f2_ok;
    push_item.hit       = (CMP_W'(f2_mx) < CMP_W'(f2_rx)) &&
                          (CMP_W'(f2_my) < CMP_W'(f2_ry));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_scale <= acet_pkg::SCALE_RESET;
      f1_valid   <= 1'b0;
      f2_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_scale <= cfg_wdata;
      end
      if (in_take) begin
        f1_valid <= 1'b1;
      end else if (f1_adv) begin
        f1_valid <= 1'b0;
      end
      if (f1_adv) begin
        f2_valid <= 1'b1;
      end else if (push) begin
        f2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      f1_dx <= DIFF_W'(first_center_x) - DIFF_W'(second_center_x);
      f1_dy <= DIFF_W'(first_center_y) - DIFF_W'(second_center_y);
      f1_sx <= SUM_W'(first_width) + SUM_W'(second_width);
      f1_sy <= SUM_W'(first_height) + SUM_W'(second_height);
      f1_a  <= first_id;
      f1_b  <= second_id;
      f1_ok <= pair_ok;
    end
    if (f1_adv) begin
      f2_mx <= {abs_x, 1'b0};
      f2_my <= {abs_y, 1'b0};
      f2_rx <= REACH_W'(size_scale) * REACH_W'(f1_sx);
      f2_ry <= REACH_W'(size_scale) * REACH_W'(f1_sy);
      f2_a  <= f1_a;
      f2_b  <= f1_b;
      f2_ok <= f1_ok;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/acet_queue.sv
`default_nettype none
module acet_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire acet_pkg::pair_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output acet_pkg::pair_item_t      pop_item
);

  localparam int PTR_W = (acet_pkg::QUEUE_DEPTH > 1) ? $clog2(acet_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(acet_pkg::QUEUE_DEPTH + 1);

  acet_pkg::pair_item_t slots [acet_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(acet_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(acet_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(acet_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(acet_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule
`default_nettype wire

>>> rtl/core/acet_back.sv
`default_nettype none
module acet_back #(
  parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  output logic                      clearing,
  input  wire logic                 q_valid,
  input  wire acet_pkg::pair_item_t q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                contact_event,
  output logic                      overlapping
);

  localparam int DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_t;

  function automatic logic [IDX_W-1:0] pair_index(input acet_pkg::pair_item_t p);
    logic [31:0] full_idx;
    full_idx = 32'(p.first_id) * 32'(MAX_COLLIDERS) + 32'(p.second_id);
    return full_idx[IDX_W-1:0];
  endfunction

  logic mem [DEPTH];
  logic [IDX_W-1:0] clr_idx;

  logic                 b1_valid;
  acet_pkg::pair_item_t b1_item;
  logic                 rd_bit;
  logic                 fwd;
  logic                 fwd_bit;
  logic                 b1_adv;
  logic                 prev;
  logic [IDX_W-1:0]     q_idx;
  logic [IDX_W-1:0]     b1_idx;
  contact_t             ev_next;
  contact_t             ev_q;

  assign q_idx  = pair_index(q_item);
  assign b1_idx = pair_index(b1_item);
  assign b1_adv = b1_valid && (!out_valid || !out_stall);
  assign q_pop  = q_valid && !clearing && (!b1_valid || b1_adv);
  assign prev   = fwd ? fwd_bit : rd_bit;

  always_comb begin
    ev_next = EV_NONE;
    if (b1_item.pair_ok) begin
      if (b1_item.hit) begin
        ev_next = prev ? EV_STAY : EV_ENTER;
      end else if (prev) begin
        ev_next = EV_EXIT;
      end
    end
  end

  assign contact_event = ev_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == IDX_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        b1_valid <= 1'b1;
      end else if (b1_adv) begin
        b1_valid <= 1'b0;
      end
      if (b1_adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // read-first store; the item leaving stage b1 is forwarded to the one entering
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_bit  <= mem[q_idx];
      b1_item <= q_item;
      fwd     <= b1_adv && b1_item.pair_ok && (b1_idx == q_idx);
      fwd_bit <= b1_item.hit;
    end
    if (clearing) begin
      mem[clr_idx] <= 1'b0;
    end else if (b1_adv && b1_item.pair_ok) begin
      mem[b1_idx] <= b1_item.hit;
    end
    if (b1_adv) begin
      ev_q        <= ev_next;
      overlapping <= b1_item.hit;
    end
  end

  a_enter_stay_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ev_q == EV_ENTER || ev_q == EV_STAY) |-> overlapping)
    else $error("enter or stay without overlap");
  a_exit_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && ev_q == EV_EXIT |-> !overlapping)
    else $error("exit while overlapping");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !b1_valid && !out_valid && !q_pop)
    else $error("item in flight during clear pass");

endmodule
`default_nettype wire

>>> rtl/core/aabb_contact_event_tracker_core.sv
// Path: an accepted item passes stages f1 and f2, the pair queue and stage b1 before its result is offered.
// Throughput: one item per cycle, sustained while the output is not stalled.
// Reset: rst (synchronous) clears control state and starts a clear pass over the
// contact store of MAX_COLLIDERS*MAX_COLLIDERS entries (4096 by default), one bit
// per cycle through the store's single write port; in_stall stays high until it ends.
// size_scale resets to 100.
`default_nettype none
module aabb_contact_event_tracker_core #(
  parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [acet_pkg::SCALE_W-1:0]        cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [acet_pkg::ID_W-1:0]           first_id,
  input  wire logic [acet_pkg::ID_W-1:0]           second_id,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_center_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_center_y,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_center_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_center_y,
  input  wire logic [acet_pkg::SIZE_W-1:0]         first_width,
  input  wire logic [acet_pkg::SIZE_W-1:0]         first_height,
  input  wire logic [acet_pkg::SIZE_W-1:0]         second_width,
  input  wire logic [acet_pkg::SIZE_W-1:0]         second_height,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               contact_event,
  output logic                                     overlapping
);

  logic                 clearing;
  logic                 push;
  acet_pkg::pair_item_t push_item;
  logic                 full;
  logic                 q_pop;
  logic                 q_valid;
  acet_pkg::pair_item_t q_item;

  acet_front #(
    .MAX_COLLIDERS(MAX_COLLIDERS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .hold           (clearing),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_id       (first_id),
    .second_id      (second_id),
    .first_center_x (first_center_x),
    .first_center_y (first_center_y),
    .second_center_x(second_center_x),
    .second_center_y(second_center_y),
    .first_width    (first_width),
    .first_height   (first_height),
    .second_width   (second_width),
    .second_height  (second_height),
    .push           (push),
    .push_item      (push_item),
    .full           (full)
  );

  acet_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_item (q_item)
  );

  acet_back #(
    .MAX_COLLIDERS(MAX_COLLIDERS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .contact_event(contact_event),
    .overlapping  (overlapping)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_aabb_contact_event_tracker_core.sv
`timescale 1ns / 1ps
module tb_aabb_contact_event_tracker_core;

  localparam int ID_W    = acet_pkg::ID_W;
  localparam int COORD_W = acet_pkg::COORD_W;
  localparam int SIZE_W  = acet_pkg::SIZE_W;
  localparam int SCALE_W = acet_pkg::SCALE_W;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_N = 12;
  localparam int HOLD_CYCLES = 300;
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));

  localparam logic [1:0] CE_NONE  = 2'd0;
  localparam logic [1:0] CE_ENTER = 2'd1;
  localparam logic [1:0] CE_STAY  = 2'd2;
  localparam logic [1:0] CE_EXIT  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]           first_id;
    logic [ID_W-1:0]           second_id;
    logic signed [COORD_W-1:0] first_center_x;
    logic signed [COORD_W-1:0] first_center_y;
    logic signed [COORD_W-1:0] second_center_x;
    logic signed [COORD_W-1:0] second_center_y;
    logic [SIZE_W-1:0]         first_width;
    logic [SIZE_W-1:0]         first_height;
    logic [SIZE_W-1:0]         second_width;
    logic [SIZE_W-1:0]         second_height;
  } pair_req_t;

  typedef struct packed {
    logic [1:0] ev;
    logic       hit;
  } contact_note_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         contact_event;
  logic               overlapping;
  pair_req_t          drv = '0;

  pair_req_t     pair_feed_q[$];
  contact_note_t contact_due_q[$];
  contact_note_t due_note;
  bit            contact_seen [0:(1 << (2 * ID_W)) - 1];
  logic [SCALE_W-1:0] scale_now = acet_pkg::SCALE_RESET;
  logic [ID_W-1:0] pool_first [0:POOL_N-1];
  logic [ID_W-1:0] pool_second [0:POOL_N-1];

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int cycle_cnt;
  logic hold_req = 1'b0;
  logic hold_taken;
  int hold_left = 0;

  aabb_contact_event_tracker_core DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .first_id        (drv.first_id),
    .second_id       (drv.second_id),
    .first_center_x  (drv.first_center_x),
    .first_center_y  (drv.first_center_y),
    .second_center_x (drv.second_center_x),
    .second_center_y (drv.second_center_y),
    .first_width     (drv.first_width),
    .first_height    (drv.first_height),
    .second_width    (drv.second_width),
    .second_height   (drv.second_height),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .contact_event   (contact_event),
    .overlapping     (overlapping)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit axis_hit(input logic signed [COORD_W-1:0] ca, cb,
                                  input logic [SIZE_W-1:0] da, db,
                                  input logic [SCALE_W-1:0] s);
    longint gap;
    longint span;
    gap = longint'(ca) - longint'(cb);
    if (gap < 0) gap = -gap;
    span = longint'(s) * (longint'(da) + longint'(db));
    return 2 * gap < span;
  endfunction

  task automatic track_contact(input pair_req_t p);
    contact_note_t e;
    logic [2*ID_W-1:0] slot;
    e.hit = axis_hit(p.first_center_x, p.second_center_x, p.first_width, p.second_width,
                     scale_now) &&
            axis_hit(p.first_center_y, p.second_center_y, p.first_height, p.second_height,
                     scale_now);
    e.ev = CE_NONE;
    slot = {p.first_id, p.second_id};
    if (p.first_id != p.second_id) begin
      if (e.hit) begin
        e.ev = contact_seen[slot] ? CE_STAY : CE_ENTER;
        contact_seen[slot] = 1'b1;
      end else if (contact_seen[slot]) begin
        e.ev = CE_EXIT;
        contact_seen[slot] = 1'b0;
      end
    end
    contact_due_q.push_back(e);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1) >> $urandom_range(0, 15));
  endfunction

  // partner center within roughly 5/7 of the combined reach, so about half hit
  function automatic logic signed [COORD_W-1:0] near_coord(
      input logic signed [COORD_W-1:0] c, input longint span);
    longint v;
    longint off;
    off = longint'($urandom) % (span * 5 / 7 + 1);
    v = ($urandom_range(1) != 0) ? longint'(c) + off : longint'(c) - off;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return COORD_W'(v);
  endfunction

  task automatic push_pair(input logic [ID_W-1:0] a, b,
                           input logic signed [COORD_W-1:0] ax, ay, bx, by,
                           input logic [SIZE_W-1:0] aw, ah, bw, bh);
    pair_req_t p;
    p.first_id = a;
    p.second_id = b;
    p.first_center_x = ax;
    p.first_center_y = ay;
    p.second_center_x = bx;
    p.second_center_y = by;
    p.first_width = aw;
    p.first_height = ah;
    p.second_width = bw;
    p.second_height = bh;
    pair_feed_q.push_back(p);
  endtask

  task automatic refresh_pairs();
    int k;
    for (k = 0; k < POOL_N; k++) begin
      pool_first[k] = ID_W'($urandom);
      pool_second[k] = ID_W'($urandom);
    end
  endtask

  task automatic push_random(input int n);
    pair_req_t p;
    int k;
    int roll;
    int pick;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll >= 88) begin
        p.first_id = ID_W'($urandom);
        p.second_id = ID_W'($urandom);
        p.first_center_x = COORD_W'($urandom);
        p.first_center_y = COORD_W'($urandom);
        p.second_center_x = COORD_W'($urandom);
        p.second_center_y = COORD_W'($urandom);
        p.first_width = SIZE_W'($urandom);
        p.first_height = SIZE_W'($urandom);
        p.second_width = SIZE_W'($urandom);
        p.second_height = SIZE_W'($urandom);
      end else begin
        pick = $urandom_range(POOL_N - 1);
        p.first_id = pool_first[pick];
        p.second_id = (roll < 80) ? pool_second[pick] : pool_first[pick];
        p.first_width = rand_size();
        p.first_height = rand_size();
        p.second_width = rand_size();
        p.second_height = rand_size();
        p.first_center_x = COORD_W'($urandom);
        p.first_center_y = COORD_W'($urandom);
        p.second_center_x = near_coord(p.first_center_x, longint'(scale_now) *
            (longint'(p.first_width) + longint'(p.second_width)));
        p.second_center_y = near_coord(p.first_center_y, longint'(scale_now) *
            (longint'(p.first_height) + longint'(p.second_height)));
      end
      pair_feed_q.push_back(p);
    end
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_now = v;
  endtask

  task automatic drain();
    while (pair_feed_q.size() != 0 || in_valid || contact_due_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_contact(drv);
      if (!in_valid || !in_stall) begin
        if (pair_feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv <= pair_feed_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (contact_due_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected item: event %0d overlapping %0b", contact_event, overlapping);
        end else begin
          due_note = contact_due_q.pop_front();
          if (contact_event !== due_note.ev || overlapping !== due_note.hit) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected event %0d overlapping %0b, got event %0d overlapping %0b",
                       due_note.ev, due_note.hit, contact_event, overlapping);
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset scale of 100: unit boxes reach 25600 apart on each axis
    push_pair(3, 3, 0, 0, 0, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 0, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 1000, 0, 256, 256, 256, 256);
    push_pair(2, 1, 0, 0, 0, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 25600, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 25600, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 25599, 0, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, -25599, -25599, 256, 256, 256, 256);
    push_pair(1, 2, 0, 0, 0, -25600, 256, 256, 256, 256);
    push_pair(2, 1, 0, 0, 25600, 0, 256, 256, 256, 256);
    push_pair(63, 0, -8388608, -8388608, 8388607, 8388607, 65535, 65535, 65535, 65535);
    push_pair(0, 63, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0);
    push_pair(0, 63, -8388608, -8388608, -8388608, -8388608, 65535, 65535, 65535, 65535);
    push_pair(63, 63, 100, 100, 100, 100, 65535, 65535, 65535, 65535);
    push_pair(0, 0, -8388608, 0, 8388607, 0, 1, 1, 1, 1);
    push_pair(0, 63, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0);
    push_pair(62, 61, 0, 0, 10, 900000, 256, 256, 256, 256);
    push_pair(62, 61, 0, 0, 900000, 10, 256, 256, 256, 256);
    push_pair(62, 61, 500, -500, 599, -401, 1, 1, 1, 1);
    push_pair(62, 61, 500, -500, 600, -401, 1, 1, 1, 1);
    drain();

    write_scale(8'd255);
    refresh_pairs();
    push_random(450);
    while (pair_feed_q.size() > 400) @(posedge clk);
    hold_req <= 1'b1;
    drain();

    // zero scale: no pair overlaps, so held contacts from the pool that come up again exit
    write_scale(8'd0);
    idle_pct = 79;
    push_pair(1, 2, 0, 0, 0, 0, 65535, 65535, 65535, 65535);
    push_pair(0, 63, 0, 0, 0, 0, 65535, 65535, 65535, 65535);
    push_random(150);
    drain();

    write_scale(SCALE_W'($urandom_range(2, 254)));
    refresh_pairs();
    idle_pct = 0;
    stall_pct = 79;
    push_random(450);
    drain();

    write_scale(8'd1);
    idle_pct = 24;
    stall_pct = 24;
    push_random(350);
    drain();

    write_scale(8'd100);
    idle_pct = 0;
    stall_pct = 0;
    push_random(350);
    drain();

    if (err_cnt == 0 && contact_due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
